FILE: rtl/ncf_pkg.sv
// ----------------------------------------------------------------------------
// ncf_pkg
// Shared constants and types for the Newton cubic fractal pixel engine.
// ----------------------------------------------------------------------------
package ncf_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int ITER_BITS_DEF  = 10;
  localparam int PIXEL_BITS_DEF = 12;

  localparam int FRAC     = 28;
  localparam int DW       = 32;
  localparam int SIDE_W   = 13;
  localparam int SHIFT_W  = 16;
  localparam int CFG_IDX_W = 3;

  // Divider widths: a 64-bit numerator with FRAC fraction bits below it.
  localparam int QUO_W     = 64 + FRAC;
  localparam int DIV_DEN_W = 64;

  localparam logic signed [63:0] DMAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] ONE_Q   = 64'sh0000_0000_1000_0000;
  localparam logic [63:0]        CONV_SQ = 64'd720575940;
  localparam logic [11:0]        COLOUR_STEP = 12'hFFF;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_RIGHT  = 3'd1,
    REG_BOTTOM = 3'd2,
    REG_TOP    = 3'd3,
    REG_SHX    = 3'd4,
    REG_SHY    = 3'd5,
    REG_SIDE   = 3'd6,
    REG_LIMIT  = 3'd7
  } reg_idx_t;

  // Clamp to the symmetric datapath range.
  function automatic logic signed [63:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      if (v > DMAX) r = DMAX;
      else if (v < -DMAX) r = -DMAX;
      else r = v;
      return r;
    end
  endfunction

endpackage

FILE: rtl/ncf_if.sv
// ----------------------------------------------------------------------------
// ncf_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface ncf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ncf_divider.sv
// ----------------------------------------------------------------------------
// ncf_divider
// Restoring divider, one quotient bit per cycle, unsigned NUM_W by DEN_W.
// ----------------------------------------------------------------------------
module ncf_divider
  import ncf_pkg::*;
#(
  parameter int NUM_W = QUO_W,
  parameter int DEN_W = DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] d_r;
  logic [DEN_W:0]   trial;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign done  = busy_r && (cnt_r == '0);
  assign quo   = q_r;

  // One shift and compare a cycle.
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      q_nxt    = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = DEN_W'(trial - {1'b0, d_r});
          q_nxt   = {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DEN_W-1:0];
          q_nxt   = {q_r[NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) d_r <= den;
  end

endmodule

FILE: rtl/newton_cubic_fractal_pixel.sv
// ----------------------------------------------------------------------------
// newton_cubic_fractal_pixel
// Maps a pixel to a complex start value and runs Newton steps for z^3 - 1.
// ----------------------------------------------------------------------------
//   channel | dir | payload
//   in_     | in  | pixel_col, pixel_row
//   out_    | out | out_col, out_row, iterations, colour, stalled
//   cfg_    | in  | index (3 bits), data (64 bits)
//
// One pixel at a time. The word is taken, then mapped with two serial
// divides. Each Newton step uses the shared 32x32 multiplier and two 92-bit
// serial divides. The closing test uses the multiplier, and a stall (zero
// derivative) ends its step before the divides.
// Reset is synchronous and restores the view registers to their defaults.
// The input is not ready until the result word has been taken.
module newton_cubic_fractal_pixel
  import ncf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ITER_BITS  = ITER_BITS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [PIXEL_BITS-1:0]      in_pixel_col,
  input  logic [PIXEL_BITS-1:0]      in_pixel_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [PIXEL_BITS-1:0]      out_out_col,
  output logic [PIXEL_BITS-1:0]      out_out_row,
  output logic [ITER_BITS-1:0]       out_iterations,
  output logic [ITER_BITS+11:0]      out_colour,
  output logic                       out_stalled,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [63:0]                cfg_data
);

  localparam int PC_W = SHIFT_W + 2;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MAP   = 12'b000000000010,
    S_MAPD  = 12'b000000000100,
    S_Z2    = 12'b000000001000,
    S_Z3    = 12'b000000010000,
    S_TEST  = 12'b000000100000,
    S_DEN   = 12'b000001000000,
    S_NUM   = 12'b000010000000,
    S_DIVR  = 12'b000100000000,
    S_DIVI  = 12'b001000000000,
    S_UPD   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [COORD_BITS-1:0] left_r, right_r, bottom_r, top_r;
  logic [SHIFT_W-1:0]    shx_r, shy_r;
  logic [SIDE_W-1:0]     side_r;
  logic [ITER_BITS-1:0]  limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= COORD_BITS'(-64'sd536870912);
      right_r  <= COORD_BITS'(64'd536870912);
      bottom_r <= COORD_BITS'(-64'sd536870912);
      top_r    <= COORD_BITS'(64'd536870912);
      shx_r    <= '0;
      shy_r    <= '0;
      side_r   <= SIDE_W'(800);
      limit_r  <= ITER_BITS'(50);
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_LEFT:   left_r   <= cfg_data[COORD_BITS-1:0];
        REG_RIGHT:  right_r  <= cfg_data[COORD_BITS-1:0];
        REG_BOTTOM: bottom_r <= cfg_data[COORD_BITS-1:0];
        REG_TOP:    top_r    <= cfg_data[COORD_BITS-1:0];
        REG_SHX:    shx_r    <= cfg_data[SHIFT_W-1:0];
        REG_SHY:    shy_r    <= cfg_data[SHIFT_W-1:0];
        REG_SIDE:   side_r   <= cfg_data[SIDE_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Bounds widened and clamped to the datapath range.
  logic signed [63:0] left_s, right_s, bottom_s, top_s;
  assign left_s   = sat64(64'(signed'(left_r)));
  assign right_s  = sat64(64'(signed'(right_r)));
  assign bottom_s = sat64(64'(signed'(bottom_r)));
  assign top_s    = sat64(64'(signed'(top_r)));

  // Shared multiplier: one 32x32 signed product a cycle, operands registered.
  logic signed [31:0] ma_r, mb_r;
  logic signed [63:0] mp_r;
  always_ff @(posedge clk) mp_r <= ma_r * mb_r;

  // Shared divider.
  logic             dv_start;
  logic [QUO_W-1:0] dv_num, dv_quo;
  logic [63:0]      dv_den;
  logic             dv_done;
  ncf_divider #(
    .NUM_W(QUO_W),
    .DEN_W(DIV_DEN_W)
  ) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  // Working registers.
  logic [PIXEL_BITS-1:0] col_r, row_r;
  logic signed [63:0] zr_r, zi_r, z2r_r, z2i_r, fr_r, fi_r, dr_r, di_r;
  logic signed [63:0] acc_r, acc2_r, nr_r, ni_r, qr_r;
  logic [63:0] den_r;
  logic [ITER_BITS-1:0] iter_r;
  logic stalled_r;
  logic [3:0] ph_r;
  logic neg_r;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_out_col    = col_r;
  assign out_out_row    = row_r;
  assign out_iterations = iter_r;
  assign out_colour     = (ITER_BITS+12)'(iter_r) * (ITER_BITS+12)'(COLOUR_STEP);
  assign out_stalled    = stalled_r;

  // Signed quotient with truncation toward zero then magnitude clamp.
  function automatic logic signed [63:0] qfix(input logic [QUO_W-1:0] q, input logic n);
    logic [63:0] m;
    begin
      m = (q > QUO_W'(DMAX)) ? 64'(DMAX) : q[63:0];
      return n ? -$signed(m) : $signed(m);
    end
  endfunction

  // Floor shift of a Q.56 product back to Q.28 (arithmetic shift floors).
  function automatic logic signed [63:0] fsh(input logic signed [63:0] v, input int n);
    return v >>> n;
  endfunction

  // Mapping operands: shifted pixel index times the view span, one narrow
  // product shared by the real and the imaginary part.
  logic signed [63:0] side_s;
  logic signed [PC_W-1:0] pc_n, pr_n, map_a;
  logic signed [33:0] wd_n, hd_n, map_b;
  logic signed [PC_W+33:0] map_prod;
  assign side_s   = (side_r == '0) ? 64'sd1 : 64'($unsigned(side_r));
  assign pc_n     = PC_W'($signed({1'b0, col_r})) + PC_W'(signed'(shx_r));
  assign pr_n     = PC_W'($signed({1'b0, row_r})) + PC_W'(signed'(shy_r));
  assign wd_n     = 34'(right_s - left_s);
  assign hd_n     = 34'(top_s - bottom_s);
  assign map_a    = (ph_r == 4'd0) ? pc_n : pr_n;
  assign map_b    = (ph_r == 4'd0) ? wd_n : hd_n;
  assign map_prod = map_a * map_b;

  // Sequencer. Multiplications load the operand registers, then register the product.
  always_ff @(posedge clk) begin
    dv_start <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          col_r     <= in_pixel_col;
          row_r     <= in_pixel_row;
          iter_r    <= '0;
          stalled_r <= 1'b0;
          ph_r      <= '0;
          state_r   <= S_MAP;
        end
        // Mapping: products are exact, division by side truncates to zero.
        S_MAP: begin
          case (ph_r)
            4'd0: begin
              acc_r <= 64'(map_prod);
              ph_r <= 4'd1;
            end
            4'd1: begin
              neg_r  <= acc_r[63];
              dv_num <= {{FRAC{1'b0}}, (acc_r[63] ? 64'(-acc_r) : 64'(acc_r))};
              dv_den <= 64'(side_s);
              dv_start <= 1'b1;
              ph_r <= 4'd2; state_r <= S_MAPD;
            end
            4'd3: begin
              acc_r <= 64'(map_prod);
              ph_r <= 4'd4;
            end
            default: begin
              neg_r  <= acc_r[63];
              dv_num <= {{FRAC{1'b0}}, (acc_r[63] ? 64'(-acc_r) : 64'(acc_r))};
              dv_den <= 64'(side_s);
              dv_start <= 1'b1;
              ph_r <= 4'd5; state_r <= S_MAPD;
            end
          endcase
        end
        S_MAPD: if (dv_done) begin
          if (ph_r == 4'd2) begin
            zr_r <= sat64(left_s + (neg_r ? -$signed(dv_quo[63:0]) : $signed(dv_quo[63:0])));
            ph_r <= 4'd3; state_r <= S_MAP;
          end else begin
            zi_r <= sat64(top_s - (neg_r ? -$signed(dv_quo[63:0]) : $signed(dv_quo[63:0])));
            ph_r <= '0; state_r <= S_Z2;
          end
        end
        // z2 = z*z: three products through the shared multiplier.
        S_Z2: begin
          case (ph_r)
            4'd0: begin ma_r <= zr_r[31:0]; mb_r <= zr_r[31:0]; ph_r <= 4'd1; end
            4'd1: begin ma_r <= zi_r[31:0]; mb_r <= zi_r[31:0]; ph_r <= 4'd2; end
            4'd2: begin acc_r <= mp_r; ma_r <= zr_r[31:0]; mb_r <= zi_r[31:0]; ph_r <= 4'd3; end
            4'd3: begin acc_r <= acc_r - mp_r; ph_r <= 4'd4; end
            default: begin
              z2r_r <= sat64(fsh(acc_r, FRAC));
              z2i_r <= sat64(fsh(mp_r, FRAC-1));
              ph_r <= '0; state_r <= S_Z3;
            end
          endcase
        end
        // z3 = z2*z.
        S_Z3: begin
          case (ph_r)
            4'd0: begin ma_r <= z2r_r[31:0]; mb_r <= zr_r[31:0]; ph_r <= 4'd1; end
            4'd1: begin ma_r <= z2i_r[31:0]; mb_r <= zi_r[31:0]; ph_r <= 4'd2; end
            4'd2: begin acc_r <= mp_r; ma_r <= z2r_r[31:0]; mb_r <= zi_r[31:0]; ph_r <= 4'd3; end
            4'd3: begin acc_r <= acc_r - mp_r; ma_r <= z2i_r[31:0]; mb_r <= zr_r[31:0]; ph_r <= 4'd4; end
            4'd4: begin acc2_r <= mp_r; ph_r <= 4'd5; end
            default: begin
              fr_r <= sat64(sat64(fsh(acc_r, FRAC)) - ONE_Q);
              fi_r <= sat64(fsh(acc2_r + mp_r, FRAC));
              ph_r <= '0; state_r <= S_TEST;
            end
          endcase
        end
        // Convergence test, then limit check, then derivative.
        S_TEST: begin
          case (ph_r)
            4'd0: begin ma_r <= fr_r[31:0]; mb_r <= fr_r[31:0]; ph_r <= 4'd1; end
            4'd1: begin ma_r <= fi_r[31:0]; mb_r <= fi_r[31:0]; ph_r <= 4'd2; end
            4'd2: begin acc_r <= mp_r; ph_r <= 4'd3; end
            default: begin
              if (64'(acc_r) + 64'(mp_r) <= CONV_SQ) state_r <= S_OUT;
              else if (iter_r >= limit_r) state_r <= S_OUT;
              else begin
                iter_r <= iter_r + 1'b1;
                dr_r <= sat64(3 * z2r_r);
                di_r <= sat64(3 * z2i_r);
                state_r <= S_DEN;
              end
              ph_r <= '0;
            end
          endcase
        end
        // den = |d|^2.
        S_DEN: begin
          case (ph_r)
            4'd0: begin ma_r <= dr_r[31:0]; mb_r <= dr_r[31:0]; ph_r <= 4'd1; end
            4'd1: begin ma_r <= di_r[31:0]; mb_r <= di_r[31:0]; ph_r <= 4'd2; end
            4'd2: begin acc_r <= mp_r; ph_r <= 4'd3; end
            default: begin
              den_r <= 64'(acc_r) + 64'(mp_r);
              if (64'(acc_r) + 64'(mp_r) == 64'd0) begin
                stalled_r <= 1'b1; state_r <= S_OUT;
              end else state_r <= S_NUM;
              ph_r <= '0;
            end
          endcase
        end
        // Numerators f*conj(d).
        S_NUM: begin
          case (ph_r)
            4'd0: begin ma_r <= fr_r[31:0]; mb_r <= dr_r[31:0]; ph_r <= 4'd1; end
            4'd1: begin ma_r <= fi_r[31:0]; mb_r <= di_r[31:0]; ph_r <= 4'd2; end
            4'd2: begin acc_r <= mp_r; ma_r <= fi_r[31:0]; mb_r <= dr_r[31:0]; ph_r <= 4'd3; end
            4'd3: begin acc_r <= acc_r + mp_r; ma_r <= fr_r[31:0]; mb_r <= di_r[31:0]; ph_r <= 4'd4; end
            4'd4: begin nr_r <= acc_r; acc2_r <= mp_r; ph_r <= 4'd5; end
            default: begin
              ni_r <= acc2_r - mp_r;
              ph_r <= '0; state_r <= S_DIVR;
            end
          endcase
        end
        S_DIVR: begin
          case (ph_r)
            4'd0: begin
              // Numerator magnitude scaled by 2^28 so the quotient is Q.28.
              neg_r <= nr_r[63];
              dv_num <= {(nr_r[63] ? 64'(-nr_r) : 64'(nr_r)), {FRAC{1'b0}}};
              dv_den <= den_r;
              dv_start <= 1'b1;
              ph_r <= 4'd1;
            end
            4'd1: ph_r <= 4'd2;
            default: if (dv_done) begin
              ph_r <= '0;
              qr_r <= qfix(dv_quo, neg_r);
              state_r <= S_DIVI;
            end
          endcase
        end
        S_DIVI: begin
          case (ph_r)
            4'd0: begin
              neg_r <= ni_r[63];
              dv_num <= {(ni_r[63] ? 64'(-ni_r) : 64'(ni_r)), {FRAC{1'b0}}};
              dv_den <= den_r;
              dv_start <= 1'b1;
              ph_r <= 4'd1;
            end
            4'd1: ph_r <= 4'd2;
            default: if (dv_done) begin
              ph_r <= '0;
              zr_r <= sat64(zr_r - qr_r);
              zi_r <= sat64(zi_r - qfix(dv_quo, neg_r));
              state_r <= S_Z2;
            end
          endcase
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: verif/newton_cubic_fractal_pixel_tb.sv
// ----------------------------------------------------------------------------
// Newton cubic fractal pixel testbench
// Sends pixel words through a valid/ready channel under a range of view
// settings and idle patterns. Each result word is checked, field by field,
// against a fixed-point predictor of the mapping and the Newton iteration.
// ----------------------------------------------------------------------------
module newton_cubic_fractal_pixel_tb;
  import ncf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
  } pixel_t;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [9:0]  iterations;
    logic [21:0] colour;
    logic        stalled;
  } shade_t;

  typedef struct packed {
    reg_idx_t    idx;
    logic [63:0] value;
  } cfg_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ncf_stream_if #(.payload_t(pixel_t))    pix_ch();
  ncf_stream_if #(.payload_t(shade_t))    shade_ch();
  ncf_stream_if #(.payload_t(cfg_word_t)) cfg_ch();

  // Local copy of the view registers, updated as each write is accepted.
  logic signed [31:0] view_left, view_right, view_bottom, view_top;
  logic signed [15:0] view_shx, view_shy;
  logic [12:0]        view_side;
  logic [9:0]         view_limit;

  pixel_t pending_pixels[$];
  shade_t expected_shades[$];
  int     error_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  longint cycle_count = 0;
  longint cycle_limit = 200000;

  newton_cubic_fractal_pixel dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pix_ch.valid),
    .in_ready       (pix_ch.ready),
    .in_pixel_col   (pix_ch.data.col),
    .in_pixel_row   (pix_ch.data.row),
    .out_valid      (shade_ch.valid),
    .out_ready      (shade_ch.ready),
    .out_out_col    (shade_ch.data.col),
    .out_out_row    (shade_ch.data.row),
    .out_iterations (shade_ch.data.iterations),
    .out_colour     (shade_ch.data.colour),
    .out_stalled    (shade_ch.data.stalled),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_index      (cfg_ch.data.idx),
    .cfg_data       (cfg_ch.data.value)
  );

  // Clock with a period of 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Clamp to the symmetric Q4.28 datapath range.
  function automatic longint clamp_q(longint v);
    longint lim;
    lim = 64'sh7FFF_FFFF;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Signed quotient n * 2^28 / d, rounded toward zero, magnitude clamped.
  function automatic longint quotient_q(longint n, longint unsigned d);
    longint unsigned mag, whole, rem, q;
    mag = (n < 0) ? (64'd0 - longint'(n)) : n;
    whole = mag / d;
    rem = mag % d;
    if (whole >= 8) begin
      q = 64'h7FFF_FFFF;
    end else begin
      q = whole;
      for (int i = 0; i < FRAC; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= d) begin
          rem = rem - d;
          q = q | 64'd1;
        end
      end
    end
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Expected shade for one pixel under the current view.
  function automatic shade_t predict_shade(pixel_t p);
    longint left, right, bottom, top, side, pcol, prow, zr, zi;
    longint z2r, z2i, z3r, z3i, fr, fi, dr, di;
    longint unsigned den, mag2;
    int unsigned steps;
    logic stall;
    shade_t s;
    left = clamp_q(longint'(view_left));
    right = clamp_q(longint'(view_right));
    bottom = clamp_q(longint'(view_bottom));
    top = clamp_q(longint'(view_top));
    side = (view_side == 0) ? 1 : longint'(view_side);
    pcol = longint'(p.col) + longint'(view_shx);
    prow = longint'(p.row) + longint'(view_shy);
    zr = clamp_q(left + (pcol * (right - left)) / side);
    zi = clamp_q(top - (prow * (top - bottom)) / side);
    steps = 0;
    stall = 1'b0;
    forever begin
      z2r = clamp_q((zr * zr - zi * zi) >>> FRAC);
      z2i = clamp_q((zr * zi) >>> (FRAC - 1));
      z3r = clamp_q((z2r * zr - z2i * zi) >>> FRAC);
      z3i = clamp_q((z2r * zi + z2i * zr) >>> FRAC);
      fr = clamp_q(z3r - ONE_Q);
      fi = z3i;
      mag2 = longint'(fr * fr) + longint'(fi * fi);
      if (mag2 <= CONV_SQ) break;
      if (steps >= view_limit) break;
      steps++;
      dr = clamp_q(3 * z2r);
      di = clamp_q(3 * z2i);
      den = longint'(dr * dr) + longint'(di * di);
      if (den == 0) begin
        stall = 1'b1;
        break;
      end
      zr = clamp_q(zr - quotient_q(fr * dr + fi * di, den));
      zi = clamp_q(zi - quotient_q(fi * dr - fr * di, den));
    end
    s.col = p.col;
    s.row = p.row;
    s.iterations = steps[9:0];
    s.colour = 22'(steps * 4095);
    s.stalled = stall;
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Pixel driver: holds a word until it is taken, then idles at random.
  always @(posedge clk) begin
    logic   taken;
    logic   next_valid;
    pixel_t next_word;
    taken = pix_ch.valid && pix_ch.ready;
    if (taken) begin
      expected_shades.push_back(predict_shade(pix_ch.data));
      void'(pending_pixels.pop_front());
    end
    next_valid = pix_ch.valid && !taken;
    next_word = pix_ch.data;
    if (!next_valid && rst_n && pending_pixels.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      next_valid = 1'b1;
      next_word = pending_pixels[0];
    end
    pix_ch.valid <= next_valid;
    pix_ch.data <= next_word;
  end

  // Result monitor: stalls at random and checks each word taken.
  always @(posedge clk) begin
    shade_t want;
    if (shade_ch.valid && shade_ch.ready) begin
      if (expected_shades.size() == 0) begin
        $display("unexpected result word for pixel %0d,%0d",
                 shade_ch.data.col, shade_ch.data.row);
        error_count++;
      end else begin
        want = expected_shades.pop_front();
        if (shade_ch.data.col !== want.col)
          report_mismatch("column", shade_ch.data.col, want.col);
        if (shade_ch.data.row !== want.row)
          report_mismatch("row", shade_ch.data.row, want.row);
        if (shade_ch.data.iterations !== want.iterations)
          report_mismatch("iterations", shade_ch.data.iterations, want.iterations);
        if (shade_ch.data.colour !== want.colour)
          report_mismatch("colour", shade_ch.data.colour, want.colour);
        if (shade_ch.data.stalled !== want.stalled)
          report_mismatch("stalled", shade_ch.data.stalled, want.stalled);
      end
    end
    shade_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Write one register while the block is idle.
  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{idx: idx, value: value};
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_LEFT:   view_left = value[31:0];
      REG_RIGHT:  view_right = value[31:0];
      REG_BOTTOM: view_bottom = value[31:0];
      REG_TOP:    view_top = value[31:0];
      REG_SHX:    view_shx = value[15:0];
      REG_SHY:    view_shy = value[15:0];
      REG_SIDE:   view_side = value[12:0];
      REG_LIMIT:  view_limit = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_view(longint l, longint r, longint b, longint t,
                          int sx, int sy, int side, int limit);
    write_reg(REG_LEFT, l);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    write_reg(REG_TOP, t);
    write_reg(REG_SHX, sx);
    write_reg(REG_SHY, sy);
    write_reg(REG_SIDE, side);
    write_reg(REG_LIMIT, limit);
  endtask

  // Queue a pixel and widen the timeout by its worst-case cost.
  task automatic send_pixel(int col, int row);
    pending_pixels.push_back('{col: col[11:0], row: row[11:0]});
    cycle_limit += 4 * (400 + 250 * (longint'(view_limit) + 1)) + 2000;
  endtask

  // Wait until every word has gone out and every result has come back.
  task automatic drain();
    while (pending_pixels.size() > 0 || pix_ch.valid || expected_shades.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_view(int max_limit);
    longint half_w, half_h, cx, cy;
    int side;
    half_w = $urandom_range(32'h0800_0000, 32'h4000_0000);
    half_h = $urandom_range(32'h0800_0000, 32'h4000_0000);
    cx = longint'($signed($urandom_range(32'h0C00_0000))) - 32'h0600_0000;
    cy = longint'($signed($urandom_range(32'h0C00_0000))) - 32'h0600_0000;
    side = $urandom_range(1, 600);
    set_view(cx - half_w, cx + half_w, cy - half_h, cy + half_h,
             $urandom_range(8) == 0 ? $signed(16'($urandom)) : $urandom_range(20) - 10,
             $urandom_range(8) == 0 ? $signed(16'($urandom)) : $urandom_range(20) - 10,
             side, $urandom_range(1, max_limit));
  endtask

  initial begin
    pix_ch.valid = 1'b0;
    pix_ch.data = '0;
    shade_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '{idx: REG_LEFT, value: 64'd0};
    view_left = -32'sd536870912;
    view_right = 32'sd536870912;
    view_bottom = -32'sd536870912;
    view_top = 32'sd536870912;
    view_shx = '0;
    view_shy = '0;
    view_side = 13'd800;
    view_limit = 10'd50;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset view: corners, far pixels, and the exact origin which stalls.
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);
    send_pixel(400, 400);
    send_pixel(600, 123);
    drain();

    // Extreme bounds, extreme shifts, zero side and zero limit.
    set_view(64'h8000_0000, 64'h7FFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF,
             -32768, 32767, 0, 0);
    send_pixel(0, 0);
    send_pixel(4095, 0);
    send_pixel(2048, 4095);
    drain();
    // Unit-width view with a side of one and a limit of one.
    set_view(0, 64'h1000_0000, 0, 64'h1000_0000, 0, 0, 1, 1);
    send_pixel(0, 0);
    send_pixel(1, 1);
    send_pixel(4095, 4095);
    drain();
    // A side of 4096 and the largest limit, near the roots and on the axes.
    set_view(64'hE000_0000, 64'h2000_0000, 64'hE000_0000, 64'h2000_0000,
             0, 0, 4096, 1023);
    send_pixel(3072, 2048);
    send_pixel(2048, 2048);
    send_pixel(1024, 2048);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(1536, 1200);
    drain();

    // Random part: four idle patterns, several views in each.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 86 : (phase == 3) ? 6 : 0;
      recv_stall_pct = (phase == 2) ? 86 : (phase == 3) ? 6 : 0;
      for (int v = 0; v < 5; v++) begin
        random_view(v == 0 ? 40 : 16);
        for (int n = 0; n < 54; n++) begin
          if ($urandom_range(7) == 0)
            send_pixel($urandom_range(4095), $urandom_range(4095));
          else
            send_pixel($urandom_range(view_side), $urandom_range(view_side));
        end
        drain();
      end
    end

    if (expected_shades.size() == 0 && error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
